FILE: sv/spp_pkg.sv
// ----------------------------------------------------------------------------
// spp_pkg
// Shared types, constants and arithmetic helpers for the stereo ping-pong
// delay.
// ----------------------------------------------------------------------------
package spp_pkg;

    localparam int LINE_DEPTH = 65536;
    localparam int ADDR_W     = $clog2(LINE_DEPTH);
    localparam int SAMPLE_W   = 16;
    localparam int GAIN_W     = 16;
    localparam int PROD_W     = SAMPLE_W + GAIN_W + 1;
    localparam int Q_SHIFT    = 15;
    localparam int RND_W      = PROD_W - Q_SHIFT;
    localparam int WIDE_W     = RND_W + 1;
    localparam int CMP_W      = ((ADDR_W > GAIN_W) ? ADDR_W : GAIN_W) + 1;
    localparam int PADDR_W    = 4;
    localparam int PDATA_W    = 32;

    localparam logic [1:0] REG_DELAY    = 2'd0;
    localparam logic [1:0] REG_FEEDBACK = 2'd1;
    localparam logic [1:0] REG_MIX      = 2'd2;
    localparam logic [1:0] REG_BYPASS   = 2'd3;

    localparam logic [GAIN_W-1:0] MIX_RESET = GAIN_W'(32768);

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [PROD_W-1:0]   t_prod;
    typedef logic signed [RND_W-1:0]    t_rnd;
    typedef logic signed [WIDE_W-1:0]   t_wide;
    typedef logic [ADDR_W-1:0]          t_addr;

    typedef struct packed {
        logic [GAIN_W-1:0] delay;
        logic [GAIN_W-1:0] feedback;
        logic [GAIN_W-1:0] mix;
        logic              bypass;
    } t_cfg;

    // Round half up and drop the Q1.15 fraction.
    function automatic t_rnd f_round(input t_prod p);
        t_prod biased;
        biased = p + PROD_W'(16384);
        return t_rnd'(biased >>> Q_SHIFT);
    endfunction

    function automatic t_sample f_sat(input t_wide x);
        t_sample res;
        if (x > t_wide'(32767)) begin
            res = 16'sh7fff;
        end else if (x < -t_wide'(32768)) begin
            res = 16'sh8000;
        end else begin
            res = x[SAMPLE_W-1:0];
        end
        return res;
    endfunction

endpackage

FILE: sv/spp_ram.sv
// ----------------------------------------------------------------------------
// spp_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module spp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/spp_apb.sv
// ----------------------------------------------------------------------------
// spp_apb
// APB register file holding delay length, feedback gain, mix gain and bypass.
// ----------------------------------------------------------------------------
module spp_apb (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [spp_pkg::PADDR_W-1:0] paddr,
    input  logic [spp_pkg::PDATA_W-1:0] pwdata,
    output logic [spp_pkg::PDATA_W-1:0] prdata,
    output logic                   pready,
    output spp_pkg::t_cfg          o_cfg
);
    import spp_pkg::*;

    t_cfg       r_cfg;
    logic       w_wr;
    logic [1:0] w_idx;

    assign w_idx  = paddr[3:2];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.delay    <= '0;
            r_cfg.feedback <= '0;
            r_cfg.mix      <= MIX_RESET;
            r_cfg.bypass   <= 1'b0;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_DELAY:    r_cfg.delay    <= pwdata[GAIN_W-1:0];
                REG_FEEDBACK: r_cfg.feedback <= pwdata[GAIN_W-1:0];
                REG_MIX:      r_cfg.mix      <= pwdata[GAIN_W-1:0];
                REG_BYPASS:   r_cfg.bypass   <= pwdata[0];
                default:      r_cfg.bypass   <= r_cfg.bypass;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_DELAY:    prdata = PDATA_W'(r_cfg.delay);
            REG_FEEDBACK: prdata = PDATA_W'(r_cfg.feedback);
            REG_MIX:      prdata = PDATA_W'(r_cfg.mix);
            REG_BYPASS:   prdata = PDATA_W'(r_cfg.bypass);
            default:      prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

FILE: sv/spp_mix.sv
// ----------------------------------------------------------------------------
// spp_mix
// Rounds the registered gain products of one channel into the next feedback
// sample and the saturated dry plus wet output, or the dry sample in bypass.
// ----------------------------------------------------------------------------
module spp_mix (
    input  spp_pkg::t_prod   i_prod_fb,
    input  spp_pkg::t_prod   i_prod_mix,
    input  spp_pkg::t_sample i_dry,
    input  logic             i_bypass,
    output spp_pkg::t_sample o_fb,
    output spp_pkg::t_sample o_out
);
    import spp_pkg::*;

    t_rnd  w_fb_r;
    t_rnd  w_mix_r;
    t_wide w_sum;

    assign w_fb_r  = f_round(i_prod_fb);
    assign w_mix_r = f_round(i_prod_mix);
    assign w_sum   = t_wide'(i_dry) + t_wide'(w_mix_r);
    assign o_fb    = f_sat(t_wide'(w_fb_r));
    assign o_out   = i_bypass ? i_dry : f_sat(w_sum);

endmodule

FILE: sv/stereo_ping_pong_delay.sv
// ----------------------------------------------------------------------------
// stereo_ping_pong_delay
// Stereo ping-pong delay: mono sum cross-fed with feedback into two delay
// line RAMs, read back a programmable number of samples later.
//
//   Channel  Signals                                   Direction
//   in       i_in_valid, o_in_ready, i_left_in/right   sink
//   out      o_out_valid, i_out_ready, o_left_out/right source
//   cfg      psel, penable, pwrite, paddr, pwdata,      APB slave
//            prdata, pready
//
// One beat per cycle is accepted while the output is not stalled; an input beat
// passes the input stage, RAM read, multiply and output register in turn.
// The RAM read-modify-write loop forwards the write made in the read cycle
// and the sample being written for a zero delay.
// Unwritten line entries read as zero through a write fill count, so no
// clearing pass is needed after reset.
// A stalled output freezes the pipeline; one more input beat is still taken.
// ----------------------------------------------------------------------------
module stereo_ping_pong_delay (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic signed [15:0]          i_left_in,
    input  logic signed [15:0]          i_right_in,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic signed [15:0]          o_left_out,
    output logic signed [15:0]          o_right_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [spp_pkg::PADDR_W-1:0] paddr,
    input  logic [spp_pkg::PDATA_W-1:0] pwdata,
    output logic [spp_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);
    import spp_pkg::*;

    t_cfg w_cfg;

    spp_apb u_apb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Control.
    logic r_s1_v, r_s2_v, r_s3_v, r_out_v;
    logic w_adv, w_in_fire, w_we, w_re;

    // Write pointer and fill count.
    t_addr               r_wp;
    logic [ADDR_W:0]     r_fill;
    logic                w_written;

    // Stage 1.
    t_sample r_s1_dl, r_s1_dr, r_s1_mono;
    t_addr   r_s1_wp, r_s1_rp;
    logic    r_s1_d0;

    // Stage 2.
    t_sample r_s2_dl, r_s2_dr, r_s2_mono;
    t_addr   r_s2_wp;
    t_addr   r_s1_rp_q;
    logic    r_s2_d0, r_s2_zero;
    logic    r_fwd_v;
    t_addr   r_fwd_addr;
    t_sample r_fwd_l, r_fwd_r;

    // Stage 3.
    t_sample r_s3_dl, r_s3_dr;
    t_prod   r_pfb_l, r_pfb_r, r_pmix_l, r_pmix_r;

    // Feedback state and output register.
    t_sample r_fb_l, r_fb_r;
    t_sample r_out_l, r_out_r;

    // Input stage arithmetic.
    logic signed [SAMPLE_W:0] w_pair_sum;
    logic [CMP_W-1:0]         w_d_ext;
    t_addr                    w_d;
    logic [ADDR_W:0]          w_wrap;
    t_addr                    w_rp;

    // Stage 2 arithmetic.
    t_sample w_rd_l, w_rd_r;
    t_sample w_fbc_l, w_fbc_r;
    t_sample w_wv_l, w_wv_r;
    t_sample w_rv_l, w_rv_r;
    logic signed [GAIN_W:0] w_gfb, w_gmix;

    // Stage 3 results.
    t_sample w_nfb_l, w_nfb_r, w_o_l, w_o_r;

    assign w_adv      = !r_out_v || i_out_ready;
    assign o_in_ready = !r_s1_v || w_adv;
    assign w_in_fire  = i_in_valid && o_in_ready;
    assign w_re       = w_adv && r_s1_v;
    assign w_we       = w_adv && r_s2_v && !w_cfg.bypass;

    assign w_pair_sum = {i_left_in[SAMPLE_W-1], i_left_in}
                      + {i_right_in[SAMPLE_W-1], i_right_in};
    assign w_d_ext    = CMP_W'(w_cfg.delay);
    assign w_d        = (w_d_ext > CMP_W'(LINE_DEPTH - 1)) ? t_addr'(LINE_DEPTH - 1)
                                                           : w_d_ext[ADDR_W-1:0];
    assign w_wrap     = {1'b0, r_wp} + (ADDR_W+1)'(LINE_DEPTH) - {1'b0, w_d};
    assign w_rp       = (r_wp >= w_d) ? (r_wp - w_d) : w_wrap[ADDR_W-1:0];
    assign w_written  = (r_fill == (ADDR_W+1)'(LINE_DEPTH)) || ({1'b0, r_s1_rp} < r_fill);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_s3_v  <= 1'b0;
            r_out_v <= 1'b0;
            r_wp    <= '0;
            r_fill  <= '0;
            r_fb_l  <= '0;
            r_fb_r  <= '0;
            r_fwd_v <= 1'b0;
        end else begin
            if (w_in_fire) begin
                r_s1_v <= 1'b1;
            end else if (w_adv) begin
                r_s1_v <= 1'b0;
            end
            if (w_adv) begin
                r_s2_v  <= r_s1_v;
                r_s3_v  <= r_s2_v;
                r_out_v <= r_s3_v;
                r_fwd_v <= w_we;
            end
            if (w_in_fire && !w_cfg.bypass) begin
                r_wp <= (r_wp == t_addr'(LINE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_we && (r_fill != (ADDR_W+1)'(LINE_DEPTH))) begin
                r_fill <= r_fill + 1'b1;
            end
            if (w_adv && r_s3_v && !w_cfg.bypass) begin
                r_fb_l <= w_nfb_l;
                r_fb_r <= w_nfb_r;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_s1_dl   <= i_left_in;
            r_s1_dr   <= i_right_in;
            r_s1_mono <= w_pair_sum[SAMPLE_W:1];
            r_s1_wp   <= r_wp;
            r_s1_rp   <= w_rp;
            r_s1_d0   <= (w_d == '0);
        end
        if (w_adv) begin
            r_s2_dl    <= r_s1_dl;
            r_s2_dr    <= r_s1_dr;
            r_s2_mono  <= r_s1_mono;
            r_s2_wp    <= r_s1_wp;
            r_s2_d0    <= r_s1_d0;
            r_s2_zero  <= !w_written;
            r_fwd_addr <= r_s2_wp;
            r_fwd_l    <= w_wv_l;
            r_fwd_r    <= w_wv_r;
            r_s3_dl    <= r_s2_dl;
            r_s3_dr    <= r_s2_dr;
            r_pfb_l    <= t_prod'(w_rv_l) * t_prod'(w_gfb);
            r_pfb_r    <= t_prod'(w_rv_r) * t_prod'(w_gfb);
            r_pmix_l   <= t_prod'(w_rv_l) * t_prod'(w_gmix);
            r_pmix_r   <= t_prod'(w_rv_r) * t_prod'(w_gmix);
            r_out_l    <= w_o_l;
            r_out_r    <= w_o_r;
        end
    end

    spp_ram #(.WIDTH(SAMPLE_W), .DEPTH(LINE_DEPTH)) u_left_line (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_s2_wp),
        .i_wdata (w_wv_l),
        .i_re    (w_re),
        .i_raddr (r_s1_rp),
        .o_rdata (w_rd_l)
    );

    spp_ram #(.WIDTH(SAMPLE_W), .DEPTH(LINE_DEPTH)) u_right_line (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_s2_wp),
        .i_wdata (w_wv_r),
        .i_re    (w_re),
        .i_raddr (r_s1_rp),
        .o_rdata (w_rd_r)
    );

    assign w_fbc_l = r_s3_v ? w_nfb_l : r_fb_l;
    assign w_fbc_r = r_s3_v ? w_nfb_r : r_fb_r;
    assign w_wv_l  = f_sat(t_wide'(r_s2_mono) + t_wide'(w_fbc_r));
    assign w_wv_r  = f_sat(t_wide'(r_s2_mono) + t_wide'(w_fbc_l));
    assign w_gfb   = $signed({1'b0, w_cfg.feedback});
    assign w_gmix  = $signed({1'b0, w_cfg.mix});

    always_comb begin
        priority if (r_s2_d0) begin
            w_rv_l = w_wv_l;
            w_rv_r = w_wv_r;
        end else if (r_fwd_v && (r_fwd_addr == r_s1_rp_q)) begin
            w_rv_l = r_fwd_l;
            w_rv_r = r_fwd_r;
        end else if (r_s2_zero) begin
            w_rv_l = '0;
            w_rv_r = '0;
        end else begin
            w_rv_l = w_rd_l;
            w_rv_r = w_rd_r;
        end
    end

    // Read address of the item in stage 2, for the forwarding compare.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_rp_q <= r_s1_rp;
        end
    end

    spp_mix u_mix_left (
        .i_prod_fb  (r_pfb_l),
        .i_prod_mix (r_pmix_l),
        .i_dry      (r_s3_dl),
        .i_bypass   (w_cfg.bypass),
        .o_fb       (w_nfb_l),
        .o_out      (w_o_l)
    );

    spp_mix u_mix_right (
        .i_prod_fb  (r_pfb_r),
        .i_prod_mix (r_pmix_r),
        .i_dry      (r_s3_dr),
        .i_bypass   (w_cfg.bypass),
        .o_fb       (w_nfb_r),
        .o_out      (w_o_r)
    );

    assign o_out_valid = r_out_v;
    assign o_left_out  = r_out_l;
    assign o_right_out = r_out_r;

endmodule

FILE: verif/spp_delay_checker.sv
// ----------------------------------------------------------------------------
// spp_delay_checker
// Watches the input, output and register ports of the stereo ping-pong delay.
// It keeps its own copy of the delay lines, feedback samples and register
// values, predicts the output pair for every input beat, and compares each
// output beat field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module spp_delay_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  spp_pkg::t_sample            i_left_in,
    input  spp_pkg::t_sample            i_right_in,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  spp_pkg::t_sample            i_left_out,
    input  spp_pkg::t_sample            i_right_out,
    input  logic                        i_psel,
    input  logic                        i_penable,
    input  logic                        i_pwrite,
    input  logic                        i_pready,
    input  logic [spp_pkg::PADDR_W-1:0] i_paddr,
    input  logic [spp_pkg::PDATA_W-1:0] i_pwdata,
    output int                          o_errors,
    output int                          o_pending,
    output int                          o_checked
);

    timeunit 1ns;
    timeprecision 1ps;

    import spp_pkg::*;

    typedef struct packed {
        t_sample left;
        t_sample right;
    } t_stereo;

    t_sample left_line [LINE_DEPTH];
    t_sample right_line [LINE_DEPTH];
    t_addr   write_ptr;
    t_sample fb_left;
    t_sample fb_right;
    t_cfg    cfg;
    t_stereo predicted_pairs [$];

    function automatic t_sample clip16(input longint x);
        t_sample res;
        if (x > 32767) begin
            res = 16'sh7fff;
        end else if (x < -32768) begin
            res = 16'sh8000;
        end else begin
            res = t_sample'(x);
        end
        return res;
    endfunction

    function automatic longint scale_q15(input longint s, input logic [GAIN_W-1:0] g);
        return (s * longint'(g) + 16384) >>> Q_SHIFT;
    endfunction

    function automatic t_stereo predict_echo(input t_sample dry_l, input t_sample dry_r);
        t_stereo     res;
        longint      mono;
        longint      wet_l;
        longint      wet_r;
        int unsigned span;
        t_addr       rd_ptr;
        if (cfg.bypass) begin
            res.left  = dry_l;
            res.right = dry_r;
        end else begin
            mono = (longint'(dry_l) + longint'(dry_r)) >>> 1;
            left_line[write_ptr]  = clip16(mono + fb_right);
            right_line[write_ptr] = clip16(mono + fb_left);
            span = (cfg.delay > LINE_DEPTH - 1) ? LINE_DEPTH - 1 : cfg.delay;
            rd_ptr = t_addr'(write_ptr - span);
            wet_l = left_line[rd_ptr];
            wet_r = right_line[rd_ptr];
            fb_left   = clip16(scale_q15(wet_l, cfg.feedback));
            fb_right  = clip16(scale_q15(wet_r, cfg.feedback));
            res.left  = clip16(dry_l + scale_q15(wet_l, cfg.mix));
            res.right = clip16(dry_r + scale_q15(wet_r, cfg.mix));
            write_ptr = write_ptr + 1'b1;
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_stereo want;
        if (!i_rst_n) begin
            for (int k = 0; k < LINE_DEPTH; k++) begin
                left_line[k]  = '0;
                right_line[k] = '0;
            end
            write_ptr = '0;
            fb_left   = '0;
            fb_right  = '0;
            cfg.delay    = '0;
            cfg.feedback = '0;
            cfg.mix      = MIX_RESET;
            cfg.bypass   = 1'b0;
            predicted_pairs.delete();
            o_errors  = 0;
            o_pending = 0;
            o_checked = 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[PADDR_W-1:2])
                    REG_DELAY:    cfg.delay    = i_pwdata[GAIN_W-1:0];
                    REG_FEEDBACK: cfg.feedback = i_pwdata[GAIN_W-1:0];
                    REG_MIX:      cfg.mix      = i_pwdata[GAIN_W-1:0];
                    REG_BYPASS:   cfg.bypass   = i_pwdata[0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                o_checked++;
                if (predicted_pairs.size() == 0) begin
                    o_errors++;
                    $display("%0t: output beat with no prediction waiting, actual left %0d right %0d",
                             $time, i_left_out, i_right_out);
                end else begin
                    want = predicted_pairs.pop_front();
                    if (i_left_out !== want.left) begin
                        o_errors++;
                        $display("%0t: left_out expected %0d actual %0d",
                                 $time, want.left, i_left_out);
                    end
                    if (i_right_out !== want.right) begin
                        o_errors++;
                        $display("%0t: right_out expected %0d actual %0d",
                                 $time, want.right, i_right_out);
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                predicted_pairs.push_back(predict_echo(i_left_in, i_right_in));
            end
            o_pending = predicted_pairs.size();
        end
    end

endmodule

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the stereo ping-pong delay. A short directed run
// covers sample extremes, zero and maximum delay, gains above unity and
// bypass, then random register settings each carry a burst of random stereo
// beats, with random gaps on the input and random backpressure on the output.
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import spp_pkg::*;

    localparam int ITEMS          = 650;
    localparam int WATCHDOG_LIMIT = 2000;

    logic               i_clk;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_ready;
    t_sample            i_left_in   = '0;
    t_sample            i_right_in  = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b1;
    t_sample            o_left_out;
    t_sample            o_right_out;
    logic               psel        = 1'b0;
    logic               penable     = 1'b0;
    logic               pwrite      = 1'b0;
    logic [PADDR_W-1:0] paddr       = '0;
    logic [PDATA_W-1:0] pwdata      = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    logic in_took;
    logic quiet        = 1'b0;
    int   stall_cycles = 0;
    int   idle_cycles  = 0;
    int   items_sent   = 0;
    int   settings     = 0;
    int   mismatches;
    int   pending;
    int   checked;

    stereo_ping_pong_delay DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_left_in  (i_left_in),
        .i_right_in (i_right_in),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_left_out (o_left_out),
        .o_right_out(o_right_out),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    spp_delay_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_ready (o_in_ready),
        .i_left_in  (i_left_in),
        .i_right_in (i_right_in),
        .i_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .i_left_out (o_left_out),
        .i_right_out(o_right_out),
        .i_psel     (psel),
        .i_penable  (penable),
        .i_pwrite   (pwrite),
        .i_pready   (pready),
        .i_paddr    (paddr),
        .i_pwdata   (pwdata),
        .o_errors   (mismatches),
        .o_pending  (pending),
        .o_checked  (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        in_took <= i_in_valid && o_in_ready;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || (psel && penable)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog: no beat for %0d cycles, %0d predictions waiting",
                         idle_cycles, pending);
                $display("stereo_ping_pong_delay: mismatch");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    always @(negedge i_clk) begin
        if (stall_cycles > 0) begin
            i_out_ready  <= 1'b0;
            stall_cycles <= stall_cycles - 1;
        end else if (!quiet && i_rst_n && $urandom_range(0, 7) == 0) begin
            i_out_ready  <= 1'b0;
            stall_cycles <= $urandom_range(0, 14);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    function automatic t_sample rand_sample();
        t_sample res;
        case ($urandom_range(0, 7))
            0: res = 16'sh7fff;
            1: res = 16'sh8000;
            2: res = t_sample'($urandom_range(0, 64)) - 16'sd32;
            default: res = t_sample'($urandom);
        endcase
        return res;
    endfunction

    function automatic logic [GAIN_W-1:0] pick_delay();
        logic [GAIN_W-1:0] res;
        case ($urandom_range(0, 9))
            0: res = '0;
            1: res = 16'hffff;
            2: res = GAIN_W'($urandom_range(100, 65534));
            default: res = GAIN_W'($urandom_range(1, 40));
        endcase
        return res;
    endfunction

    function automatic logic [GAIN_W-1:0] pick_gain();
        logic [GAIN_W-1:0] res;
        case ($urandom_range(0, 7))
            0: res = '0;
            1: res = 16'h8000;
            2: res = 16'hffff;
            3: res = GAIN_W'($urandom);
            default: res = GAIN_W'($urandom_range(8192, 32768));
        endcase
        return res;
    endfunction

    task automatic send_pair(input t_sample dry_l, input t_sample dry_r);
        i_in_valid <= 1'b1;
        i_left_in  <= dry_l;
        i_right_in <= dry_r;
        @(negedge i_clk);
        while (in_took !== 1'b1) @(negedge i_clk);
        items_sent++;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [GAIN_W-1:0] value,
                             input int width);
        logic [PDATA_W-1:0] mask;
        mask = (PDATA_W'(1) << width) - PDATA_W'(1);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= (PDATA_W'($urandom) & ~mask) | (PDATA_W'(value) & mask);
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
    endtask

    task automatic set_config(input logic [GAIN_W-1:0] delay_len,
                              input logic [GAIN_W-1:0] fb_gain,
                              input logic [GAIN_W-1:0] wet_gain,
                              input logic bypass_on);
        wait_drained();
        write_reg(REG_DELAY, delay_len, GAIN_W);
        write_reg(REG_FEEDBACK, fb_gain, GAIN_W);
        write_reg(REG_MIX, wet_gain, GAIN_W);
        write_reg(REG_BYPASS, GAIN_W'(bypass_on), 1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        settings++;
    endtask

    initial begin
        int len;
        int phase;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_pair(16'sh7fff, 16'sh7fff);
        send_pair(16'sh8000, 16'sh8000);
        send_pair(16'sh7fff, 16'sh8000);
        send_pair(-16'sd1, 16'sd0);
        send_pair(16'sd1, 16'sd0);
        send_pair(16'sd0, 16'sd0);

        set_config(16'd2, 16'hffff, 16'hffff, 1'b0);
        send_pair(16'sh7fff, 16'sh7fff);
        send_pair(16'sh8000, 16'sh8000);
        send_pair(16'sh7fff, 16'sh8000);
        send_pair(16'sh8000, 16'sh7fff);
        send_pair(16'sh5555, -16'sh2aab);
        send_pair(16'sd0, 16'sd0);

        set_config(16'd2, 16'hffff, 16'hffff, 1'b1);
        send_pair(16'sh7fff, 16'sh8000);
        send_pair(16'sh8000, 16'sh7fff);
        send_pair(-16'sd1, 16'sd1);

        set_config(16'hffff, 16'h8000, 16'h0000, 1'b0);
        send_pair(16'sh7fff, 16'sh7fff);
        send_pair(16'sh8000, 16'sh0001);
        send_pair(16'sd3, -16'sd3);

        set_config(16'd1, 16'h8000, 16'h8000, 1'b0);
        send_pair(16'sh7fff, 16'sh7fff);
        send_pair(16'sh8000, 16'sh8000);
        send_pair(16'sd100, -16'sd100);
        send_pair(16'sd0, 16'sd0);
        send_pair(-16'sd7, 16'sd2);

        phase = 0;
        while (items_sent < ITEMS) begin
            set_config(pick_delay(), pick_gain(), pick_gain(), $urandom_range(0, 7) == 0);
            len = $urandom_range(40, 80);
            for (int k = 0; k < len && items_sent < ITEMS; k++) begin
                if (items_sent >= ITEMS - 80) begin
                    quiet <= 1'b1;
                end
                if (phase == 2 && k == len / 2) begin
                    wait_drained();
                end
                send_pair(rand_sample(), rand_sample());
            end
            phase++;
        end

        wait_drained();
        repeat (16) @(negedge i_clk);
        $display("Sent %0d stereo beats over %0d register settings, delays 0 to 65535,",
                 items_sent, settings);
        $display("gains 0 to 65535 and bypass on and off; %0d output beats compared.",
                 checked);
        if (mismatches == 0) begin
            $display("stereo_ping_pong_delay: match");
        end else begin
            $display("stereo_ping_pong_delay: mismatch");
        end
        $finish;
    end

endmodule
